// ===== rtl/trsc_pkg.sv =====
package trsc_pkg;

   localparam int ROTOR_COUNT = 3;
   localparam int BASE_SIZE   = 27;
   localparam int MAX_SYMBOLS = 64;

   // stepping thresholds on the symbol count
   localparam int STEP_AT_A = 4;
   localparam int STEP_AT_B = 8;
   localparam int STEP_AT_C = 12;
   localparam logic [3:0] COUNT_MAX = 4'd12;

   typedef enum logic [1:0] {
      CFG_MODE      = 2'd0,
      CFG_KEY_ONE   = 2'd1,
      CFG_KEY_TWO   = 2'd2,
      CFG_KEY_THREE = 2'd3
   } cfg_index_type;

   // request kind, carried in tuser
   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_SYMBOL = 1'b1
   } action_type;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef logic [5:0] sym_table_type [MAX_SYMBOLS];
   typedef logic [4:0] base_row_type [BASE_SIZE];

   localparam base_row_type BASE_WIRING [ROTOR_COUNT] = '{
      '{5'd18, 5'd10, 5'd22, 5'd15, 5'd21, 5'd24, 5'd20, 5'd17, 5'd8,  5'd1,
        5'd11, 5'd16, 5'd0,  5'd26, 5'd7,  5'd3,  5'd12, 5'd2,  5'd19, 5'd25,
        5'd6,  5'd4,  5'd5,  5'd13, 5'd23, 5'd9,  5'd14},
      '{5'd15, 5'd7,  5'd17, 5'd10, 5'd6,  5'd26, 5'd12, 5'd3,  5'd16, 5'd22,
        5'd1,  5'd4,  5'd24, 5'd14, 5'd2,  5'd23, 5'd11, 5'd25, 5'd0,  5'd5,
        5'd18, 5'd21, 5'd13, 5'd9,  5'd19, 5'd20, 5'd8},
      '{5'd22, 5'd17, 5'd2,  5'd15, 5'd6,  5'd9,  5'd7,  5'd14, 5'd25, 5'd5,
        5'd12, 5'd21, 5'd11, 5'd10, 5'd24, 5'd8,  5'd0,  5'd18, 5'd4,  5'd3,
        5'd26, 5'd23, 5'd19, 5'd20, 5'd13, 5'd16, 5'd1}
   };

   // built-in forward wiring of rotor r for an alphabet of n symbols
   function automatic sym_table_type forward_reset(input int n, input int r);
      sym_table_type t;
      for (int p = 0; p < MAX_SYMBOLS; p++) begin
         t[p] = 6'(p);
         if (p < BASE_SIZE && p < n && int'(BASE_WIRING[r][p]) < n) begin
            t[p] = 6'(BASE_WIRING[r][p]);
         end
      end
      return t;
   endfunction

   // inverse of the built-in wiring; last writer of a value wins
   function automatic sym_table_type inverse_reset(input int n, input int r);
      sym_table_type f;
      sym_table_type t;
      f = forward_reset(n, r);
      for (int p = 0; p < MAX_SYMBOLS; p++) begin
         t[p] = 6'(p);
      end
      for (int p = 0; p < MAX_SYMBOLS; p++) begin
         if (p < n) begin
            t[f[p]] = 6'(p);
         end
      end
      return t;
   endfunction

   // key value reduced into the alphabet
   function automatic sym_table_type key_reduce(input int n);
      sym_table_type t;
      int k;
      for (int v = 0; v < MAX_SYMBOLS; v++) begin
         k = v;
         for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (k >= n) begin
               k = k - n;
            end
         end
         t[v] = 6'(k);
      end
      return t;
   endfunction

endpackage

// ===== rtl/three_rotor_substitution_cipher_top.sv =====
// A symbol request passes the three rotor stages and then the output register
// before its response is valid.
// Throughput: one request per cycle while no stall holds the stages; each rotor
// stage does one registered read of its wiring memories per cycle it advances,
// and the three stages plus the output register set the latency. Wiring writes
// give no response and pass down the same stages in order.
// Reset (synchronous): mode, keys, offsets and count clear; per-entry valid bits
// clear so every wiring reads its built-in table again at once, no sweep.
// Both input channels hold ready low while reset is high.
module three_rotor_substitution_cipher_top #(
   parameter int ALPHABET_SIZE = 27
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rotor[1:0], position[6:2], symbol[11:7], first[12]
   input  logic        req_tuser,  // action[0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_symbol[4:0]
   output logic        rsp_tuser,  // out_error[0]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int SW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ROTORS = trsc_pkg::ROTOR_COUNT;
   localparam int LAST   = ROTORS - 1;
   localparam logic [SW:0] SIZE = (SW + 1)'(ALPHABET_SIZE);

   typedef logic [SW-1:0] sym_type;

   // one item as it travels down the rotor stages
   typedef struct packed {
      logic                     vld;
      logic                     act;      // 1 symbol, 0 wiring write
      logic                     err;
      logic [1:0]               wr_rotor;
      logic                     wr_ok;
      sym_type                  wr_pos;
      sym_type                  wr_sym;
      logic [ROTORS-1:0][SW-1:0] off;
   } item_type;

   localparam trsc_pkg::sym_table_type FWD_RST [ROTORS] = '{
      trsc_pkg::forward_reset(ALPHABET_SIZE, 0),
      trsc_pkg::forward_reset(ALPHABET_SIZE, 1),
      trsc_pkg::forward_reset(ALPHABET_SIZE, 2)
   };
   localparam trsc_pkg::sym_table_type INV_RST [ROTORS] = '{
      trsc_pkg::inverse_reset(ALPHABET_SIZE, 0),
      trsc_pkg::inverse_reset(ALPHABET_SIZE, 1),
      trsc_pkg::inverse_reset(ALPHABET_SIZE, 2)
   };
   localparam trsc_pkg::sym_table_type KEY_MOD = trsc_pkg::key_reduce(ALPHABET_SIZE);

   function automatic sym_type wrap_add(input sym_type a, input sym_type b);
      logic [SW:0] t;
      t = (SW + 1)'(a) + (SW + 1)'(b);
      if (t >= SIZE) begin
         t = t - SIZE;
      end
      return t[SW-1:0];
   endfunction

   function automatic sym_type wrap_sub(input sym_type a, input sym_type b);
      logic [SW:0] t;
      t = (SW + 1)'(a) + SIZE - (SW + 1)'(b);
      if (t >= SIZE) begin
         t = t - SIZE;
      end
      return t[SW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // configuration and message state
   // ---------------------------------------------------------------------
   logic              mode_ff;
   sym_type           key_ff   [ROTORS];
   sym_type           off_ff   [ROTORS];
   sym_type           off_in   [ROTORS];
   logic [3:0]        count_ff;
   logic [3:0]        count_in;

   // ---------------------------------------------------------------------
   // wiring memories: slot s reads forward rotor s and inverse rotor LAST-s
   // ---------------------------------------------------------------------
   sym_type                  wiring_fwd_ff [ROTORS][ALPHABET_SIZE];
   sym_type                  wiring_inv_ff [ROTORS][ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] fwd_vld_ff    [ROTORS];
   logic [ALPHABET_SIZE-1:0] inv_vld_ff    [ROTORS];
   sym_type                  rd_fwd_ff     [ROTORS];  // indexed by slot
   sym_type                  rd_inv_ff     [ROTORS];  // indexed by slot

   item_type  pipe_ff [1:ROTORS];
   item_type  slot_item [ROTORS];
   sym_type   slot_x    [ROTORS];
   sym_type   fwd_addr  [ROTORS];
   logic      fwd_wr    [ROTORS];
   logic      inv_wr    [ROTORS];

   logic      rsp_vld_ff;
   logic      rsp_vld_in;
   logic [4:0] rsp_sym_ff;
   logic      rsp_err_ff;

   logic      advance;
   logic      accept;
   logic      last_res;
   logic      decrypt;
   item_type  in_item;
   logic [1:0] in_rotor;
   logic [4:0] in_pos;
   logic [4:0] in_sym;
   logic      in_first;
   logic      in_act;
   logic      in_bad;
   logic [3:0] cnt_eff;
   sym_type   base_off [ROTORS];
   sym_type   x_out;

   assign in_rotor = req_tdata[1:0];
   assign in_pos   = req_tdata[6:2];
   assign in_sym   = req_tdata[11:7];
   assign in_first = req_tdata[12];
   assign in_act   = (req_tuser == trsc_pkg::ACT_SYMBOL);
   assign decrypt  = (mode_ff == trsc_pkg::MODE_DECRYPT);

   // Stages move together; a stall only bites when the output register is
   // full, not being taken, and the last stage holds a symbol for it.
   assign last_res   = pipe_ff[ROTORS].vld && pipe_ff[ROTORS].act;
   assign advance    = rsp_tready || !rsp_vld_ff || !last_res;
   assign req_tready = advance && !reset;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   // entry stage: restart on first, then step the offsets
   always_comb begin
      in_bad  = int'(in_sym) >= ALPHABET_SIZE;
      cnt_eff = in_first ? 4'd0 : count_ff;
      for (int k = 0; k < ROTORS; k++) begin
         base_off[k] = in_first ? key_ff[k] : off_ff[k];
      end
      off_in[0] = base_off[0];
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_A)) off_in[0] = wrap_add(off_in[0], sym_type'(1));
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_B)) off_in[0] = wrap_add(off_in[0], sym_type'(1));
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_C)) off_in[0] = wrap_add(off_in[0], sym_type'(1));
      off_in[2] = base_off[2];
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_B)) off_in[2] = wrap_add(off_in[2], sym_type'(1));
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_C)) off_in[2] = wrap_add(off_in[2], sym_type'(1));
      off_in[1] = base_off[1];
      if (cnt_eff >= 4'(trsc_pkg::STEP_AT_C)) off_in[1] = wrap_add(off_in[1], sym_type'(1));
      count_in = (cnt_eff < trsc_pkg::COUNT_MAX) ? cnt_eff + 4'd1 : cnt_eff;

      in_item.vld      = accept;
      in_item.act      = in_act;
      in_item.err      = in_act && in_bad;
      in_item.wr_rotor = in_rotor;
      in_item.wr_ok    = !in_act && (int'(in_rotor) < ROTORS)
                         && (int'(in_pos) < ALPHABET_SIZE) && !in_bad;
      in_item.wr_pos   = SW'(in_pos);
      in_item.wr_sym   = SW'(in_sym);
      for (int k = 0; k < ROTORS; k++) begin
         in_item.off[k] = off_in[k];
      end
   end

   // per-slot symbol, read address and write enables
   always_comb begin
      slot_item[0] = in_item;
      slot_x[0]    = in_bad ? '0 : SW'(in_sym);
      for (int s = 1; s < ROTORS; s++) begin
         slot_item[s] = pipe_ff[s];
         // decrypt adds the offset of the rotor whose inverse was just read
         slot_x[s] = decrypt ? wrap_add(rd_inv_ff[s-1], pipe_ff[s].off[ROTORS-s])
                             : rd_fwd_ff[s-1];
      end
      for (int s = 0; s < ROTORS; s++) begin
         fwd_addr[s] = wrap_sub(slot_x[s], slot_item[s].off[s]);
         fwd_wr[s]   = advance && slot_item[s].vld && slot_item[s].wr_ok
                       && (slot_item[s].wr_rotor == 2'(s));
         inv_wr[s]   = advance && slot_item[s].vld && slot_item[s].wr_ok
                       && (slot_item[s].wr_rotor == 2'(LAST - s));
      end
   end

   // Each memory is touched at one slot only, so reads and writes keep
   // request order without forwarding.
   for (genvar s = 0; s < ROTORS; s++) begin : g_slot
      always_ff @(posedge clock) begin
         if (advance) begin
            rd_fwd_ff[s] <= fwd_vld_ff[s][fwd_addr[s]] ? wiring_fwd_ff[s][fwd_addr[s]]
                                                     : SW'(FWD_RST[s][6'(fwd_addr[s])]);
            rd_inv_ff[s] <= inv_vld_ff[LAST-s][slot_x[s]]
                            ? wiring_inv_ff[LAST-s][slot_x[s]]
                            : SW'(INV_RST[LAST-s][6'(slot_x[s])]);
         end
         if (fwd_wr[s]) begin
            wiring_fwd_ff[s][slot_item[s].wr_pos] <= slot_item[s].wr_sym;
         end
         if (inv_wr[s]) begin
            wiring_inv_ff[LAST-s][slot_item[s].wr_sym] <= slot_item[s].wr_pos;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fwd_vld_ff[s]      <= '0;
            inv_vld_ff[LAST-s] <= '0;
         end else begin
            if (fwd_wr[s]) begin
               fwd_vld_ff[s][slot_item[s].wr_pos] <= 1'b1;
            end
            if (inv_wr[s]) begin
               inv_vld_ff[LAST-s][slot_item[s].wr_sym] <= 1'b1;
            end
         end
      end
   end

   // stage registers and message state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= ROTORS; s++) begin
            pipe_ff[s] <= '0;
         end
         for (int k = 0; k < ROTORS; k++) begin
            off_ff[k] <= '0;
         end
         count_ff <= '0;
      end else begin
         if (advance) begin
            pipe_ff[1] <= in_item;
            for (int s = 1; s < ROTORS; s++) begin
               pipe_ff[s+1] <= pipe_ff[s];
            end
         end
         if (accept && in_act) begin
            for (int k = 0; k < ROTORS; k++) begin
               off_ff[k] <= off_in[k];
            end
            count_ff <= count_in;
         end
      end
   end

   // register writes; keys are stored already reduced into the alphabet
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= trsc_pkg::MODE_ENCRYPT;
         for (int k = 0; k < ROTORS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         unique case (trsc_pkg::cfg_index_type'(csr_index))
            trsc_pkg::CFG_MODE:      mode_ff   <= csr_wdata[0];
            trsc_pkg::CFG_KEY_ONE:   key_ff[0] <= SW'(KEY_MOD[6'(csr_wdata)]);
            trsc_pkg::CFG_KEY_TWO:   key_ff[1] <= SW'(KEY_MOD[6'(csr_wdata)]);
            trsc_pkg::CFG_KEY_THREE: key_ff[2] <= SW'(KEY_MOD[6'(csr_wdata)]);
         endcase
      end
   end

   // output register
   assign x_out = decrypt ? wrap_add(rd_inv_ff[LAST], pipe_ff[ROTORS].off[0])
                          : rd_fwd_ff[LAST];

   always_comb begin
      if (advance && last_res) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_res) begin
         rsp_sym_ff <= pipe_ff[ROTORS].err ? 5'd0 : 5'(x_out);
         rsp_err_ff <= pipe_ff[ROTORS].err;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_sym_ff};
   assign rsp_tuser  = rsp_err_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_vld_ff |-> req_tready)
      else $error("request stalled with empty output register");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= trsc_pkg::COUNT_MAX)
      else $error("symbol count above saturation");

   a_offsets_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(off_ff[0]) < ALPHABET_SIZE) && (int'(off_ff[1]) < ALPHABET_SIZE)
      && (int'(off_ff[2]) < ALPHABET_SIZE))
      else $error("rotor offset outside alphabet");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == trsc_pkg::ACT_SYMBOL) && req_tdata[12])
      |=> (count_ff == 4'd1))
      else $error("first symbol did not restart the count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && last_res && pipe_ff[ROTORS].err) |=> (rsp_sym_ff == 5'd0))
      else $error("invalid symbol gave nonzero code");

endmodule
